@@ rtl/lgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED drive gain control package
// Shared types, register indices and reset values for the gain control block.
// ----------------------------------------------------------------------------
package lgc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int TARGET_W   = 18;
    localparam int LEVEL_W    = 8;
    localparam int STEP_W     = 7;
    localparam int INTERVAL_W = 16;
    localparam int SETTLE_W   = 8;
    localparam int TIME_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED_MIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_UP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES = 3'd7;

    localparam logic [TARGET_W-1:0]   RST_LOW_THRESH     = 18'd15000;
    localparam logic [TARGET_W-1:0]   RST_HIGH_THRESH    = 18'd50000;
    localparam logic [LEVEL_W-1:0]    RST_LED_MIN        = 8'h3F;
    localparam logic [LEVEL_W-1:0]    RST_INITIAL_LEVEL  = 8'h7F;
    localparam logic [STEP_W-1:0]     RST_STEP_UP        = 7'h08;
    localparam logic [STEP_W-1:0]     RST_STEP_DOWN      = 7'h04;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL_MS    = 16'd500;
    localparam logic [SETTLE_W-1:0]   RST_SETTLE_SAMPLES = 8'd20;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

    typedef struct packed {
        logic [TARGET_W-1:0]   low_thresh;
        logic [TARGET_W-1:0]   high_thresh;
        logic [LEVEL_W-1:0]    led_min;
        logic [LEVEL_W-1:0]    initial_level;
        logic [STEP_W-1:0]     step_up;
        logic [STEP_W-1:0]     step_down;
        logic [INTERVAL_W-1:0] interval_ms;
        logic [SETTLE_W-1:0]   settle_samples;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] led_level;
        logic               skip_sample;
        logic               led_write;
    } res_t;

endpackage

@@ rtl/lgc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED gain control configuration registers
// Holds the eight control registers written through the configuration port.
// ----------------------------------------------------------------------------
module lgc_cfg (
    input  logic            aclk,
    input  logic            aresetn,
    input  lgc_pkg::cfg_wr_t cfg_wr,
    output lgc_pkg::cfg_t    cfg
);

    lgc_pkg::cfg_t cfg_reg;
    lgc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr.valid) begin
            case (cfg_wr.index)
                lgc_pkg::REG_LOW_THRESH: begin
                    cfg_next.low_thresh = cfg_wr.data[lgc_pkg::TARGET_W-1:0];
                end
                lgc_pkg::REG_HIGH_THRESH: begin
                    cfg_next.high_thresh = cfg_wr.data[lgc_pkg::TARGET_W-1:0];
                end
                lgc_pkg::REG_LED_MIN: begin
                    cfg_next.led_min = cfg_wr.data[lgc_pkg::LEVEL_W-1:0];
                end
                lgc_pkg::REG_INITIAL_LEVEL: begin
                    cfg_next.initial_level = cfg_wr.data[lgc_pkg::LEVEL_W-1:0];
                end
                lgc_pkg::REG_STEP_UP: begin
                    cfg_next.step_up = cfg_wr.data[lgc_pkg::STEP_W-1:0];
                end
                lgc_pkg::REG_STEP_DOWN: begin
                    cfg_next.step_down = cfg_wr.data[lgc_pkg::STEP_W-1:0];
                end
                lgc_pkg::REG_INTERVAL_MS: begin
                    cfg_next.interval_ms = cfg_wr.data[lgc_pkg::INTERVAL_W-1:0];
                end
                lgc_pkg::REG_SETTLE_SAMPLES: begin
                    cfg_next.settle_samples = cfg_wr.data[lgc_pkg::SETTLE_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_thresh     <= lgc_pkg::RST_LOW_THRESH;
            cfg_reg.high_thresh    <= lgc_pkg::RST_HIGH_THRESH;
            cfg_reg.led_min        <= lgc_pkg::RST_LED_MIN;
            cfg_reg.initial_level  <= lgc_pkg::RST_INITIAL_LEVEL;
            cfg_reg.step_up        <= lgc_pkg::RST_STEP_UP;
            cfg_reg.step_down      <= lgc_pkg::RST_STEP_DOWN;
            cfg_reg.interval_ms    <= lgc_pkg::RST_INTERVAL_MS;
            cfg_reg.settle_samples <= lgc_pkg::RST_SETTLE_SAMPLES;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/lgc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED gain control state and decision logic
// Keeps the accumulator, settle counter and drive level, and computes the
// result of one request. Threshold products track the sample count so the
// average compare needs only adds and compares.
// ----------------------------------------------------------------------------
module lgc_ctrl #(
    parameter int DC_BITS     = 18,
    parameter int MAX_SAMPLES = 1023
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lgc_pkg::cfg_t                     cfg,
    input  lgc_pkg::cfg_wr_t                  cfg_wr,
    input  logic                              fire,
    input  logic [DC_BITS-1:0]                dc_level,
    input  logic [lgc_pkg::TIME_W-1:0]        now_ms,
    input  logic                              finger_on,
    input  logic                              activate,
    output lgc_pkg::res_t                     res
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = DC_BITS + CNT_W;
    localparam int PROD_W = lgc_pkg::TARGET_W + CNT_W;
    localparam int CMP_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 3;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam int LW = lgc_pkg::LEVEL_W;

    logic [LW-1:0]                 level_reg,  level_next;
    logic [SUM_W-1:0]              sum_reg,    sum_next;
    logic [CNT_W-1:0]              cnt_reg,    cnt_next;
    logic [PROD_W-1:0]             low_n_reg,  low_n_next;
    logic [PROD_W-1:0]             high_n_reg, high_n_next;
    logic [lgc_pkg::TIME_W-1:0]    last_reg,   last_next;
    logic [lgc_pkg::SETTLE_W-1:0]  settle_reg, settle_next;
    logic                          en_reg,     en_next;

    logic                          can_add;
    logic [SUM_W-1:0]              sum_acc;
    logic [CNT_W-1:0]              cnt_acc;
    logic [PROD_W-1:0]             low_acc;
    logic [PROD_W-1:0]             high_acc;
    logic [lgc_pkg::TIME_W-1:0]    elapsed;
    logic                          due;
    logic [CMP_W-1:0]              s_ext, l_ext, h_ext;
    logic                          below, far_below, above, far_above;
    logic [LW-1:0]                 up_step, dn_step;
    logic [LW:0]                   up_sum, dn_floor;
    logic [LW-1:0]                 up_level, dn_level, new_level;
    logic                          changed;
    logic [lgc_pkg::SETTLE_W-1:0]  settle_cur;
    logic                          en_cur;
    logic                          skip, wr;

    assign can_add  = cnt_reg < MAX_CNT;
    assign sum_acc  = can_add ? sum_reg + SUM_W'(dc_level) : sum_reg;
    assign cnt_acc  = can_add ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign low_acc  = can_add ? low_n_reg + PROD_W'(cfg.low_thresh) : low_n_reg;
    assign high_acc = can_add ? high_n_reg + PROD_W'(cfg.high_thresh) : high_n_reg;

    assign elapsed = now_ms - last_reg;
    assign due     = (elapsed >= lgc_pkg::TIME_W'(cfg.interval_ms)) && (cnt_acc != '0);

    assign s_ext     = CMP_W'(sum_acc);
    assign l_ext     = CMP_W'(low_acc);
    assign h_ext     = CMP_W'(high_acc);
    assign below     = s_ext < l_ext;
    assign far_below = (s_ext << 1) < l_ext;
    assign above     = s_ext > h_ext;
    assign far_above = ((s_ext << 2) + s_ext) > ((h_ext << 2) + (h_ext << 1));

    assign up_step  = far_below ? {cfg.step_up, 1'b0} : {1'b0, cfg.step_up};
    assign dn_step  = far_above ? {cfg.step_down, 1'b0} : {1'b0, cfg.step_down};
    assign up_sum   = {1'b0, level_reg} + {1'b0, up_step};
    assign up_level = up_sum[LW] ? lgc_pkg::LEVEL_MAX : up_sum[LW-1:0];
    assign dn_floor = {1'b0, dn_step} + {1'b0, cfg.led_min};
    assign dn_level = ({1'b0, level_reg} >= dn_floor) ? (level_reg - dn_step) : cfg.led_min;
    assign new_level = below ? up_level : (above ? dn_level : level_reg);
    assign changed   = new_level != level_reg;

    assign settle_cur = activate ? cfg.settle_samples : settle_reg;
    assign en_cur     = en_reg | activate;

    always_comb begin
        level_next  = level_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        low_n_next  = low_n_reg;
        high_n_next = high_n_reg;
        last_next   = last_reg;
        settle_next = settle_reg;
        en_next     = en_reg;
        skip        = 1'b0;
        wr          = 1'b0;
        if (fire) begin
            if (!finger_on) begin
                level_next  = cfg.initial_level;
                sum_next    = '0;
                cnt_next    = '0;
                low_n_next  = '0;
                high_n_next = '0;
                last_next   = '0;
                settle_next = '0;
                en_next     = 1'b0;
                wr          = 1'b1;
            end else begin
                en_next     = en_cur;
                settle_next = settle_cur;
                if (en_cur) begin
                    if (settle_cur != '0) begin
                        settle_next = settle_cur - lgc_pkg::SETTLE_W'(1);
                        skip        = 1'b1;
                    end else if (due) begin
                        sum_next    = '0;
                        cnt_next    = '0;
                        low_n_next  = '0;
                        high_n_next = '0;
                        last_next   = now_ms;
                        if (changed) begin
                            level_next  = new_level;
                            settle_next = cfg.settle_samples;
                            skip        = 1'b1;
                            wr          = 1'b1;
                        end
                    end else begin
                        sum_next    = sum_acc;
                        cnt_next    = cnt_acc;
                        low_n_next  = low_acc;
                        high_n_next = high_acc;
                    end
                end
            end
        end
        if (cfg_wr.valid && (cfg_wr.index == lgc_pkg::REG_LOW_THRESH)) begin
            low_n_next = PROD_W'(cfg_wr.data[lgc_pkg::TARGET_W-1:0]) * PROD_W'(cnt_reg);
        end
        if (cfg_wr.valid && (cfg_wr.index == lgc_pkg::REG_HIGH_THRESH)) begin
            high_n_next = PROD_W'(cfg_wr.data[lgc_pkg::TARGET_W-1:0]) * PROD_W'(cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= lgc_pkg::RST_INITIAL_LEVEL;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            low_n_reg  <= '0;
            high_n_reg <= '0;
            last_reg   <= '0;
            settle_reg <= '0;
            en_reg     <= 1'b0;
        end else begin
            level_reg  <= level_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            low_n_reg  <= low_n_next;
            high_n_reg <= high_n_next;
            last_reg   <= last_next;
            settle_reg <= settle_next;
            en_reg     <= en_next;
        end
    end

    assign res.led_level   = level_next;
    assign res.skip_sample = skip;
    assign res.led_write   = wr;

endmodule

@@ rtl/led_drive_gain_control_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED drive gain control
// Path: an accepted request is held in the input register; the state update then
//   writes its result into the result register once the output is free.
// Throughput: one request per cycle unless stalled; single-pass state update.
// Reset: synchronous, active low; clears the pipeline, the accumulator and
//   restores the control registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module led_drive_gain_control_top #(
    parameter int DC_BITS     = 18,
    parameter int MAX_SAMPLES = 1023
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [DC_BITS-1:0]                s_dc_level,
    input  logic [31:0]                       s_now_ms,
    input  logic                              s_finger_on,
    input  logic                              s_activate,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_led_level,
    output logic                              m_skip_sample,
    output logic                              m_led_write,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lgc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                        in_vld_reg, in_vld_next;
    logic [DC_BITS-1:0]          dc_reg, dc_next;
    logic [31:0]                 now_reg, now_next;
    logic                        finger_reg, finger_next;
    logic                        act_reg, act_next;
    logic                        out_vld_reg, out_vld_next;
    lgc_pkg::res_t               res_reg, res_next;
    lgc_pkg::res_t               res;
    lgc_pkg::cfg_t               cfg;
    lgc_pkg::cfg_wr_t            cfg_wr;
    logic                        out_free;
    logic                        fire;
    logic                        take;

    assign out_free = !out_vld_reg || m_ready;
    assign fire     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;
    assign take     = s_valid && s_ready;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    lgc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .cfg     (cfg)
    );

    lgc_ctrl #(
        .DC_BITS     (DC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cfg_wr    (cfg_wr),
        .fire      (fire),
        .dc_level  (dc_reg),
        .now_ms    (now_reg),
        .finger_on (finger_reg),
        .activate  (act_reg),
        .res       (res)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        dc_next     = dc_reg;
        now_next    = now_reg;
        finger_next = finger_reg;
        act_next    = act_reg;
        if (s_ready) begin
            in_vld_next = s_valid;
        end
        if (take) begin
            dc_next     = s_dc_level;
            now_next    = s_now_ms;
            finger_next = s_finger_on;
            act_next    = s_activate;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        res_next     = res_reg;
        if (out_free) begin
            out_vld_next = in_vld_reg;
        end
        if (fire) begin
            res_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        dc_reg     <= dc_next;
        now_reg    <= now_next;
        finger_reg <= finger_next;
        act_reg    <= act_next;
        res_reg    <= res_next;
    end

    assign m_valid       = out_vld_reg;
    assign m_led_level   = res_reg.led_level;
    assign m_skip_sample = res_reg.skip_sample;
    assign m_led_write   = res_reg.led_write;

endmodule

@@ rtl/lgc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED gain control port checker
// Watches the top-level ports for pipeline and handshake consistency.
// ----------------------------------------------------------------------------
module lgc_checker #(
    parameter int DC_BITS = 18
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [DC_BITS-1:0]             s_dc_level,
    input logic [31:0]                    s_now_ms,
    input logic                           s_finger_on,
    input logic                           s_activate,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [7:0]                     m_led_level,
    input logic                           m_skip_sample,
    input logic                           m_led_write
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_level)
            && $stable(m_skip_sample) && $stable(m_led_write))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_dc_level) && $stable(s_now_ms)
            && $stable(s_finger_on) && $stable(s_activate))
        else $error("request changed while stalled");

    a_rise_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without preceding request");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind led_drive_gain_control_top lgc_checker #(.DC_BITS(DC_BITS)) u_lgc_checker (.*);

@@ sim/led_drive_gain_control_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED drive gain control regression
// Sends optical DC samples and register writes into led_drive_gain_control_top
// under random sender gaps and receiver stalls. A scoreboard tracks the drive
// level, settle window and DC accumulator for each accepted request and checks
// every result, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module led_drive_gain_control_top_tb;

    localparam int DC_W        = 18;
    localparam int SAMPLE_CAP  = 1023;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [DC_W-1:0] DC_MAX = '1;

    class drive_level_scoreboard;
        lgc_pkg::cfg_t                 regs;
        logic [lgc_pkg::LEVEL_W-1:0]   drive_level;
        logic [27:0]                   dc_sum;
        logic [9:0]                    sample_count;
        logic [lgc_pkg::TIME_W-1:0]    last_adjust_ms;
        logic [lgc_pkg::SETTLE_W-1:0]  settle_left;
        logic                          enabled;
        lgc_pkg::res_t                 pending_updates[$];
        int                            mismatches;

        function new();
            regs.low_thresh     = lgc_pkg::RST_LOW_THRESH;
            regs.high_thresh    = lgc_pkg::RST_HIGH_THRESH;
            regs.led_min        = lgc_pkg::RST_LED_MIN;
            regs.initial_level  = lgc_pkg::RST_INITIAL_LEVEL;
            regs.step_up        = lgc_pkg::RST_STEP_UP;
            regs.step_down      = lgc_pkg::RST_STEP_DOWN;
            regs.interval_ms    = lgc_pkg::RST_INTERVAL_MS;
            regs.settle_samples = lgc_pkg::RST_SETTLE_SAMPLES;
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            drive_level    = regs.initial_level;
            dc_sum         = '0;
            sample_count   = '0;
            last_adjust_ms = '0;
            settle_left    = '0;
            enabled        = 1'b0;
        endfunction

        function void write_reg(logic [lgc_pkg::CFG_IDX_W-1:0] idx,
                                logic [lgc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lgc_pkg::REG_LOW_THRESH:
                    regs.low_thresh = data[lgc_pkg::TARGET_W-1:0];
                lgc_pkg::REG_HIGH_THRESH:
                    regs.high_thresh = data[lgc_pkg::TARGET_W-1:0];
                lgc_pkg::REG_LED_MIN:
                    regs.led_min = data[lgc_pkg::LEVEL_W-1:0];
                lgc_pkg::REG_INITIAL_LEVEL:
                    regs.initial_level = data[lgc_pkg::LEVEL_W-1:0];
                lgc_pkg::REG_STEP_UP:
                    regs.step_up = data[lgc_pkg::STEP_W-1:0];
                lgc_pkg::REG_STEP_DOWN:
                    regs.step_down = data[lgc_pkg::STEP_W-1:0];
                lgc_pkg::REG_INTERVAL_MS:
                    regs.interval_ms = data[lgc_pkg::INTERVAL_W-1:0];
                lgc_pkg::REG_SETTLE_SAMPLES:
                    regs.settle_samples = data[lgc_pkg::SETTLE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [DC_W-1:0] dc, logic [lgc_pkg::TIME_W-1:0] now_ms,
                                  logic finger_on, logic activate);
            lgc_pkg::res_t              upd;
            logic [lgc_pkg::TIME_W-1:0] elapsed;
            logic [39:0]                sum;
            logic [39:0]                low_bound;
            logic [39:0]                high_bound;
            logic [8:0]                 step;
            logic [8:0]                 next_level;
            upd.skip_sample = 1'b0;
            upd.led_write   = 1'b0;
            if (!finger_on) begin
                clear_state();
                upd.led_write = 1'b1;
            end else begin
                if (activate) begin
                    enabled     = 1'b1;
                    settle_left = regs.settle_samples;
                end
                if (enabled && settle_left != 0) begin
                    settle_left     = settle_left - 8'd1;
                    upd.skip_sample = 1'b1;
                end else if (enabled) begin
                    // hold the sum once the count saturates
                    if (sample_count < 10'(SAMPLE_CAP)) begin
                        dc_sum       = dc_sum + 28'(dc);
                        sample_count = sample_count + 10'd1;
                    end
                    elapsed = now_ms - last_adjust_ms;
                    if (elapsed >= 32'(regs.interval_ms) && sample_count != 0) begin
                        sum        = 40'(dc_sum);
                        low_bound  = 40'(regs.low_thresh) * 40'(sample_count);
                        high_bound = 40'(regs.high_thresh) * 40'(sample_count);
                        next_level = {1'b0, drive_level};
                        dc_sum         = '0;
                        sample_count   = '0;
                        last_adjust_ms = now_ms;
                        if (sum < low_bound) begin
                            step = ((sum << 1) < low_bound) ? {1'b0, regs.step_up, 1'b0}
                                                            : {2'b0, regs.step_up};
                            next_level = {1'b0, drive_level} + step;
                            if (next_level > {1'b0, lgc_pkg::LEVEL_MAX})
                                next_level = {1'b0, lgc_pkg::LEVEL_MAX};
                        end else if (sum > high_bound) begin
                            step = (((sum << 2) + sum) > ((high_bound << 2) + (high_bound << 1)))
                                 ? {1'b0, regs.step_down, 1'b0} : {2'b0, regs.step_down};
                            next_level = ({1'b0, drive_level} >= step + {1'b0, regs.led_min})
                                       ? {1'b0, drive_level} - step : {1'b0, regs.led_min};
                        end
                        if (next_level != {1'b0, drive_level}) begin
                            drive_level     = next_level[lgc_pkg::LEVEL_W-1:0];
                            settle_left     = regs.settle_samples;
                            upd.skip_sample = 1'b1;
                            upd.led_write   = 1'b1;
                        end
                    end
                end
            end
            upd.led_level = drive_level;
            pending_updates.push_back(upd);
        endfunction

        function void check_update(lgc_pkg::res_t got);
            lgc_pkg::res_t want;
            if (pending_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected update: level %0d skip %0b write %0b",
                             got.led_level, got.skip_sample, got.led_write);
                return;
            end
            want = pending_updates.pop_front();
            if (got.led_level !== want.led_level || got.skip_sample !== want.skip_sample ||
                got.led_write !== want.led_write) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("update mismatch: expected level %0d skip %0b write %0b, %s",
                             want.led_level, want.skip_sample, want.led_write,
                             $sformatf("got level %0d skip %0b write %0b",
                                       got.led_level, got.skip_sample, got.led_write));
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn       = 1'b0;
    logic                           s_valid       = 1'b0;
    logic                           s_ready;
    logic [DC_W-1:0]                s_dc_level    = '0;
    logic [31:0]                    s_now_ms      = '0;
    logic                           s_finger_on   = 1'b0;
    logic                           s_activate    = 1'b0;
    logic                           m_valid;
    logic                           m_ready       = 1'b0;
    logic [7:0]                     m_led_level;
    logic                           m_skip_sample;
    logic                           m_led_write;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [lgc_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [lgc_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    int          tx_idle_pct = 28;
    int          rx_idle_pct = 61;
    int          cycle_count = 0;
    logic [31:0] ms_clock    = '0;

    drive_level_scoreboard levels = new();

    led_drive_gain_control_top #(
        .DC_BITS    (DC_W),
        .MAX_SAMPLES(SAMPLE_CAP)
    ) DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_drive_gain_control_top regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                levels.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                levels.note_sample(s_dc_level, s_now_ms, s_finger_on, s_activate);
            if (m_valid && m_ready)
                levels.check_update({m_led_level, m_skip_sample, m_led_write});
        end
    end

    task automatic send_sample(input logic [DC_W-1:0] dc, input logic [31:0] now_ms,
                               input logic finger_on, input logic activate);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_dc_level  <= dc;
        s_now_ms    <= now_ms;
        s_finger_on <= finger_on;
        s_activate  <= activate;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lgc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [17:0] t_low, input logic [17:0] t_high,
                                input logic [7:0] l_min, input logic [7:0] init_level,
                                input logic [6:0] s_up, input logic [6:0] s_down,
                                input logic [15:0] interval, input logic [7:0] settle);
        write_reg(lgc_pkg::REG_LOW_THRESH, t_low);
        write_reg(lgc_pkg::REG_HIGH_THRESH, t_high);
        write_reg(lgc_pkg::REG_LED_MIN, 18'(l_min));
        write_reg(lgc_pkg::REG_INITIAL_LEVEL, 18'(init_level));
        write_reg(lgc_pkg::REG_STEP_UP, 18'(s_up));
        write_reg(lgc_pkg::REG_STEP_DOWN, 18'(s_down));
        write_reg(lgc_pkg::REG_INTERVAL_MS, 18'(interval));
        write_reg(lgc_pkg::REG_SETTLE_SAMPLES, 18'(settle));
        cfg_valid <= 1'b0;
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (levels.pending_updates.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // scenes of similar DC level, so that averages land in every band
    task automatic run_scenes(input int count, input int t_low, input int t_high);
        int              band_edge[6];
        int              zone;
        logic [DC_W-1:0] dc;
        band_edge = '{0, t_low / 2, t_low, t_high, t_high + t_high / 5, int'(DC_MAX)};
        for (int z = 0; z < 6; z++)
            if (band_edge[z] > int'(DC_MAX))
                band_edge[z] = int'(DC_MAX);
        zone = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 8 == 0)
                zone = int'($urandom_range(4));
            ms_clock = ms_clock + $urandom_range(12, 1);
            if ($urandom_range(9) == 0)
                dc = DC_W'($urandom);
            else
                dc = DC_W'($urandom_range(band_edge[zone + 1], band_edge[zone]));
            send_sample(dc, ms_clock, $urandom_range(99) >= 2,
                        i == 0 || $urandom_range(99) < 4);
        end
    endtask

    initial begin
        int rand_low;
        int rand_high;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        program_regs(1000, 5000, 63, 100, 8, 4, 10, 2);
        send_sample(0, 0, 1'b0, 1'b1);
        send_sample(DC_MAX, 5, 1'b1, 1'b0);
        send_sample(200, 10, 1'b1, 1'b1);
        send_sample(200, 12, 1'b1, 1'b0);
        send_sample(200, 14, 1'b1, 1'b0);
        send_sample(800, 16, 1'b1, 1'b0);
        send_sample(800, 18, 1'b1, 1'b0);
        send_sample(800, 20, 1'b1, 1'b0);
        send_sample(800, 24, 1'b1, 1'b0);
        send_sample(9000, 26, 1'b1, 1'b0);
        send_sample(9000, 28, 1'b1, 1'b0);
        send_sample(9000, 40, 1'b1, 1'b0);
        send_sample(5500, 44, 1'b1, 1'b0);
        send_sample(5500, 48, 1'b1, 1'b0);
        send_sample(5500, 60, 1'b1, 1'b0);
        send_sample(3000, 64, 1'b1, 1'b0);
        send_sample(3000, 70, 1'b1, 1'b0);
        send_sample(3000, 80, 1'b1, 1'b0);
        send_sample(3000, 85, 1'b1, 1'b1);
        send_sample(3000, 86, 1'b1, 1'b0);
        send_sample(3000, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_sample(0, 5, 1'b1, 1'b0);
        send_sample(0, 9, 1'b1, 1'b0);
        quiesce();

        program_regs(4000, 12000, 63, 127, 8, 4, 40, 3);
        ms_clock = $urandom;
        run_scenes(120, 4000, 12000);
        quiesce();

        tx_idle_pct = 61;
        rx_idle_pct = 28;
        program_regs(DC_MAX, DC_MAX, 0, 0, 127, 127, 0, 0);
        ms_clock = $urandom;
        run_scenes(100, int'(DC_MAX), int'(DC_MAX));
        quiesce();

        // lowering from below the floor lifts the level to it
        program_regs(0, 0, 200, 10, 0, 127, 0, 0);
        run_scenes(100, 0, 0);
        quiesce();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rand_low  = int'($urandom_range(60000));
        rand_high = int'($urandom_range(120000));
        program_regs(18'(rand_low), 18'(rand_high), 8'($urandom), 8'($urandom),
                     7'($urandom), 7'($urandom),
                     16'($urandom_range(100)), 8'($urandom_range(6)));
        ms_clock = $urandom;
        run_scenes(100, rand_low, rand_high);
        quiesce();

        // accumulate over a long interval, then jump the clock to force a decision
        program_regs(2000, 3000, 0, 127, 1, 1, 16'hFFFF, 0);
        send_sample(0, 0, 1'b0, 1'b0);
        send_sample(2500, 1, 1'b1, 1'b1);
        repeat (40) send_sample(DC_W'($urandom_range(4000)), 100, 1'b1, 1'b0);
        send_sample(2500, 70000, 1'b1, 1'b0);
        quiesce();

        repeat (8) @(posedge aclk);
        if (levels.pending_updates.size() != 0)
            $display("%0d expected updates never arrived", levels.pending_updates.size());
        if (levels.mismatches == 0 && levels.pending_updates.size() == 0)
            $display("led_drive_gain_control_top regression: pass");
        else
            $display("led_drive_gain_control_top regression: fail");
        $finish;
    end

endmodule
